### rtl/mcr_pkg.sv
// Shared types, constants and saturation helpers for the channel routing core.
// Used by muskingum_cell_route_floodplain_core; depends on nothing else.
package mcr_pkg;

    localparam int unsigned NUM_CELLS_DEF = 1024;
    localparam int unsigned CELL_W        = 10;
    localparam int unsigned STEP_W        = 17;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd86400;

    // 100 m3/s in Q23.8.
    localparam logic [30:0] BIG_MEAN = 31'd25600;
    localparam logic [30:0] CAP_MAX  = 31'h7FFF_FFFF;
    localparam logic [46:0] V47_MAX  = 47'h7FFF_FFFF_FFFF;

    // One memory row: prev inflow, prev outflow, river storage, floodplain storage.
    localparam int unsigned ROW_W = 32 + 32 + 48 + 47;

    typedef struct packed {
        logic signed [31:0] up;
        logic signed [31:0] ro;
        logic [30:0]        mean;
        logic signed [15:0] c0;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic signed [31:0] pin;
        logic signed [31:0] pout;
        logic signed [47:0] store;
        logic [46:0]        flood;
        logic signed [31:0] inq;
        logic [30:0]        cap;
        logic signed [32:0] d;
        logic signed [50:0] prod;
        logic signed [47:0] p0;
        logic signed [47:0] p1;
        logic signed [47:0] p2;
        logic signed [31:0] outq;
    } mcr_item_t;

    function automatic logic signed [31:0] sat_q(input logic signed [50:0] x);
        logic signed [31:0] r;
        if (x > 51'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -51'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat_v48(input logic signed [50:0] x);
        logic signed [47:0] r;
        if (x > 51'sd140737488355327)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (x < -51'sd140737488355328)
            r = 48'sh8000_0000_0000;
        else
            r = x[47:0];
        return r;
    endfunction

endpackage

### rtl/muskingum_cell_route_floodplain_core.sv
// Muskingum routing core with floodplain exchange, per-cell state in one RAM (mcr_pkg, mcr_ram).
// out_valid rises once the input beat has passed the whole pipeline; when the floodplain drains
// fully, stage 4 holds the beat while it divides bit-serially by the step length.
// Throughput: one beat per cycle for distinct cells while out_stall and the stage 4 divide
// do not hold the pipeline; a beat for a cell still in it waits until that cell's row is written back.
// Reset: step length 86400 s, then a clearing sweep zeroes every RAM row with input stalled.
module muskingum_cell_route_floodplain_core #(
    parameter int unsigned NUM_CELLS = mcr_pkg::NUM_CELLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [9:0]          cell_index,
    input  logic signed [31:0]  upstream_inflow,
    input  logic signed [31:0]  runoff_flow,
    input  logic signed [15:0]  coef_current_in,
    input  logic signed [15:0]  coef_previous_in,
    input  logic signed [15:0]  coef_previous_out,
    input  logic [30:0]         mean_discharge,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  capped_inflow,
    output logic signed [31:0]  outflow,
    output logic signed [47:0]  storage_change,
    output logic signed [47:0]  river_volume,
    output logic [46:0]         floodplain_volume,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [16:0]         cfg_data
);

    localparam int unsigned AW    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int unsigned NST   = 9;
    localparam int unsigned MOD_M = (NUM_CELLS >= 1024) ? 1
                                    : ((1 << 20) + NUM_CELLS - 1) / NUM_CELLS;
    localparam int unsigned RW    = mcr_pkg::ROW_W;

    // Configuration.
    logic [16:0]        step_seconds_reg;
    logic signed [17:0] dt_s;

    // Clearing sweep.
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Pipeline.
    mcr_pkg::mcr_item_t st_reg [1:NST];
    mcr_pkg::mcr_item_t st_nxt [2:NST];
    logic [AW-1:0]      cell_reg [1:NST];
    logic [NST:1]       vld_reg;
    logic [NST:1]       adv;
    mcr_pkg::mcr_item_t in_item;

    // Input cell reduction.
    logic [30:0]   mod_prod;
    logic [9:0]    mod_q;
    logic [9:0]    mod_r;
    logic [AW-1:0] in_cell;
    logic          hazard;
    logic          accept;

    // RAM.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    // Stage locals.
    logic signed [32:0] insum;
    logic [35:0]        capw;
    logic signed [50:0] room;
    logic signed [50:0] flood51;
    logic signed [50:0] fsum;
    logic               need_div;
    logic signed [49:0] acc;
    logic signed [49:0] sh;
    logic signed [31:0] outq0;
    logic signed [47:0] fin_chg;
    logic signed [48:0] sum49;
    logic signed [47:0] fin_store;
    logic signed [31:0] fin_outq;

    // Divider.
    logic          div_busy_reg;
    logic          div_done_reg;
    logic [4:0]    div_cnt_reg;
    logic [16:0]   div_rem_reg;
    logic [31:0]   div_q_reg;
    logic [31:0]   div_low;
    logic [17:0]   div_t;
    logic          div_ge;
    logic [17:0]   div_diff;

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] capped_inflow_reg;
    logic signed [31:0] outflow_reg;
    logic signed [47:0] storage_change_reg;
    logic signed [47:0] river_volume_reg;
    logic [46:0]        floodplain_volume_reg;
    logic               out_free;

    assign dt_s      = $signed({1'b0, step_seconds_reg});
    assign cfg_ready = 1'b1;

    // Cell index modulo NUM_CELLS by reciprocal multiply for small cell counts.
    always_comb
    begin
        mod_prod = 31'(cell_index) * 31'(MOD_M);
        mod_q    = mod_prod[29:20];
        mod_r    = cell_index - 10'(20'(mod_q) * 20'(NUM_CELLS));
        if (NUM_CELLS >= 1024)
            in_cell = AW'(cell_index);
        else
            in_cell = AW'(mod_r);
    end

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 1; k <= NST; k++)
        begin
            if (vld_reg[k] && (cell_reg[k] == in_cell))
                hazard = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        adv[NST] = vld_reg[NST] && out_free;
        for (int k = NST - 1; k >= 1; k--)
        begin
            adv[k] = vld_reg[k] && (!vld_reg[k+1] || adv[k+1]);
        end
        if (need_div && !div_done_reg)
            adv[4] = 1'b0;
        // Stage 4 holding back must also hold stages 1 to 3.
        for (int k = 3; k >= 1; k--)
        begin
            adv[k] = vld_reg[k] && (!vld_reg[k+1] || adv[k+1]);
        end
    end

    assign in_stall = clearing_reg || hazard || (vld_reg[1] && !adv[1]);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_item      = '0;
        in_item.up   = upstream_inflow;
        in_item.ro   = runoff_flow;
        in_item.mean = mean_discharge;
        in_item.c0   = coef_current_in;
        in_item.c1   = coef_previous_in;
        in_item.c2   = coef_previous_out;
    end

    // Stage functions.
    always_comb
    begin
        // Stage 1: state from RAM, inflow sum and capacity.
        st_nxt[2]       = st_reg[1];
        st_nxt[2].pin   = ram_rdata[158:127];
        st_nxt[2].pout  = ram_rdata[126:95];
        st_nxt[2].store = ram_rdata[94:47];
        st_nxt[2].flood = ram_rdata[46:0];
        insum           = {st_reg[1].up[31], st_reg[1].up} + {st_reg[1].ro[31], st_reg[1].ro};
        st_nxt[2].inq   = mcr_pkg::sat_q(51'(insum));
        if (st_reg[1].mean > mcr_pkg::BIG_MEAN)
            capw = {2'b00, st_reg[1].mean, 3'b000};
        else
            capw = {1'b0, st_reg[1].mean, 4'b0000} + {3'b000, st_reg[1].mean, 2'b00};
        if (capw > {5'b00000, mcr_pkg::CAP_MAX})
            st_nxt[2].cap = mcr_pkg::CAP_MAX;
        else
            st_nxt[2].cap = capw[30:0];

        // Stage 2: excess over capacity.
        st_nxt[3]   = st_reg[2];
        st_nxt[3].d = {st_reg[2].inq[31], st_reg[2].inq} - {2'b00, st_reg[2].cap};

        // Stage 3: excess times step length.
        st_nxt[4]      = st_reg[3];
        st_nxt[4].prod = 51'(st_reg[3].d) * 51'(dt_s);

        // Stage 4: floodplain spill or drain-back.
        st_nxt[5] = st_reg[4];
        room      = -st_reg[4].prod;
        flood51   = $signed({4'b0000, st_reg[4].flood});
        fsum      = flood51 + st_reg[4].prod;
        need_div  = 1'b0;
        if (!st_reg[4].d[32] && (st_reg[4].d != 33'sd0))
        begin
            if (fsum > $signed({4'b0000, mcr_pkg::V47_MAX}))
                st_nxt[5].flood = mcr_pkg::V47_MAX;
            else
                st_nxt[5].flood = fsum[46:0];
            st_nxt[5].inq = $signed({1'b0, st_reg[4].cap});
        end
        else if (st_reg[4].flood != 47'd0)
        begin
            if (room < flood51)
            begin
                st_nxt[5].flood = st_reg[4].flood - room[46:0];
                st_nxt[5].inq   = $signed({1'b0, st_reg[4].cap});
            end
            else
            begin
                need_div        = vld_reg[4];
                st_nxt[5].flood = 47'd0;
                st_nxt[5].inq   = mcr_pkg::sat_q(51'(st_reg[4].inq)
                                                 + $signed({19'd0, div_q_reg}));
            end
        end

        // Stage 5: Muskingum products.
        st_nxt[6]    = st_reg[5];
        st_nxt[6].p0 = 48'(st_reg[5].c0) * 48'(st_reg[5].inq);
        st_nxt[6].p1 = 48'(st_reg[5].c1) * 48'(st_reg[5].pin);
        st_nxt[6].p2 = 48'(st_reg[5].c2) * 48'(st_reg[5].pout);

        // Stage 6: sum, round half up to Q23.8, saturate, negative fallback.
        st_nxt[7] = st_reg[6];
        acc       = 50'(st_reg[6].p0) + 50'(st_reg[6].p1) + 50'(st_reg[6].p2) + 50'sd8192;
        sh        = acc >>> 14;
        outq0     = mcr_pkg::sat_q(51'(sh));
        if (outq0[31])
            st_nxt[7].outq = $signed({1'b0, st_reg[6].mean});
        else
            st_nxt[7].outq = outq0;

        // Stage 7: inflow minus outflow.
        st_nxt[8]   = st_reg[7];
        st_nxt[8].d = {st_reg[7].inq[31], st_reg[7].inq} - {st_reg[7].outq[31], st_reg[7].outq};

        // Stage 8: storage change before saturation.
        st_nxt[9]      = st_reg[8];
        st_nxt[9].prod = 51'(st_reg[8].d) * 51'(dt_s);

        // Stage 9: river storage update with the non-positive storage guard.
        fin_chg = mcr_pkg::sat_v48(st_reg[9].prod);
        sum49   = {st_reg[9].store[47], st_reg[9].store} + {fin_chg[47], fin_chg};
        if (!sum49[48] && (sum49 != 49'sd0))
        begin
            fin_store = mcr_pkg::sat_v48(51'(sum49));
            fin_outq  = st_reg[9].outq;
        end
        else
        begin
            fin_store = st_reg[9].store;
            fin_chg   = 48'sd0;
            fin_outq  = st_reg[9].inq;
        end
    end

    // Bit-serial divide of the floodplain by the step length, one quotient bit a cycle.
    always_comb
    begin
        div_low  = st_reg[4].flood[31:0];
        div_t    = {div_rem_reg, div_low[div_cnt_reg]};
        div_ge   = div_t >= {1'b0, step_seconds_reg};
        div_diff = div_t - {1'b0, step_seconds_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_rem_reg  <= '0;
            div_q_reg    <= '0;
        end
        else if (adv[4])
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
        end
        else if (need_div && !div_busy_reg && !div_done_reg)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= 5'd31;
            div_rem_reg  <= {2'b00, st_reg[4].flood[46:32]};
            div_q_reg    <= '0;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_ge ? div_diff[16:0] : div_t[16:0];
            div_q_reg   <= {div_q_reg[30:0], div_ge};
            if (div_cnt_reg == 5'd0)
            begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
            else
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_seconds_reg <= mcr_pkg::STEP_RESET;
            clearing_reg     <= 1'b1;
            clr_cnt_reg      <= '0;
            vld_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                step_seconds_reg <= cfg_data;
            if (clearing_reg)
            begin
                if (clr_cnt_reg == AW'(NUM_CELLS - 1))
                    clearing_reg <= 1'b0;
                else
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (accept)
                vld_reg[1] <= 1'b1;
            else if (adv[1])
                vld_reg[1] <= 1'b0;
            for (int k = 2; k <= NST; k++)
            begin
                if (adv[k-1])
                    vld_reg[k] <= 1'b1;
                else if (adv[k])
                    vld_reg[k] <= 1'b0;
            end
            if (adv[NST])
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg[1]   <= in_item;
            cell_reg[1] <= in_cell;
        end
        for (int k = 2; k <= NST; k++)
        begin
            if (adv[k-1])
            begin
                st_reg[k]   <= st_nxt[k];
                cell_reg[k] <= cell_reg[k-1];
            end
        end
        if (adv[NST])
        begin
            capped_inflow_reg     <= st_reg[NST].inq;
            outflow_reg           <= fin_outq;
            storage_change_reg    <= fin_chg;
            river_volume_reg      <= fin_store;
            floodplain_volume_reg <= st_reg[NST].flood;
        end
    end

    // Write-back of the finished beat, or zero rows during the clearing sweep.
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = adv[NST];
            ram_waddr = cell_reg[NST];
            ram_wdata = {st_reg[NST].inq, fin_outq, fin_store, st_reg[NST].flood};
        end
    end

    mcr_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_CELLS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_cell),
        .rdata (ram_rdata)
    );

    assign out_valid         = out_valid_reg;
    assign capped_inflow     = capped_inflow_reg;
    assign outflow           = outflow_reg;
    assign storage_change    = storage_change_reg;
    assign river_volume      = river_volume_reg;
    assign floodplain_volume = floodplain_volume_reg;

endmodule

### rtl/mcr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; width and depth come from parameters.
module mcr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
